FILE: rtl/qbvs_pkg.sv
package qbvs_pkg;

  localparam int MAX_QUADS     = 8192;
  localparam int TEXTURE_SLOTS = 32;

  // Quad counter must hold MAX_QUADS itself, slot counter TEXTURE_SLOTS itself.
  localparam int QCW     = $clog2(MAX_QUADS + 1);
  localparam int SCW     = $clog2(TEXTURE_SLOTS + 1);
  localparam int SLOT_AW = $clog2(TEXTURE_SLOTS);

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_FLAT  = 2'd1,
    CMD_TEX   = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_VERTEX  = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_NO_SLOT = 2'd2,
    KIND_NO_ROOM = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP_RD,
    ST_LOOKUP_CMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [31:0] color_rgba;
    logic [31:0] texture_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] vert_x;
    logic [31:0] vert_y;
    logic [31:0] vert_z;
    logic        tex_u;
    logic        tex_v;
    logic [31:0] vert_color;
    logic [4:0]  slot_index;
    logic        is_last;
    logic [15:0] index_count;
    logic [5:0]  slots_in_use;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic  capture;
    logic  clear_scene;
    logic  rd_en;
    logic  idx_inc;
    logic  take_hit;
    logic  alloc;
    logic  quad_inc;
    logic  kind_ld;
    kind_e kind;
    logic  corner_inc;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic batch_full;
    logic slots_full;
    logic scan_done;
    logic hit;
    logic rec_last;
  } dp_sts_t;

endpackage

FILE: rtl/qbvs_ram.sv
module qbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/qbvs_ctrl.sv
module qbvs_ctrl import qbvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  input  logic       out_ready_i,
  input  dp_sts_t    sts_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_BEGIN: state_d = ST_IDLE;
            CMD_END:   state_d = ST_EMIT;
            CMD_FLAT:  state_d = ST_EMIT;
            CMD_TEX:   state_d = sts_i.batch_full ? ST_EMIT : ST_LOOKUP_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP_RD:  state_d = sts_i.scan_done ? ST_EMIT : ST_LOOKUP_CMP;
      ST_LOOKUP_CMP: state_d = sts_i.hit ? ST_EMIT : ST_LOOKUP_RD;
      ST_EMIT: begin
        if (out_ready_i && sts_i.rec_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = KIND_VERTEX;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_cmd_i)
            CMD_BEGIN: cmd_o.clear_scene = 1'b1;
            CMD_END: begin
              cmd_o.kind_ld = 1'b1;
              cmd_o.kind    = KIND_SUMMARY;
            end
            CMD_FLAT, CMD_TEX: begin
              cmd_o.kind_ld = 1'b1;
              if (sts_i.batch_full) begin
                cmd_o.kind = KIND_NO_ROOM;
              end else begin
                cmd_o.kind     = KIND_VERTEX;
                cmd_o.quad_inc = (in_cmd_i == CMD_FLAT);
              end
            end
            default: cmd_o.capture = 1'b1;
          endcase
        end
      end
      ST_LOOKUP_RD: begin
        if (!sts_i.scan_done) begin
          cmd_o.rd_en = 1'b1;
        end else if (sts_i.slots_full) begin
          cmd_o.kind_ld = 1'b1;
          cmd_o.kind    = KIND_NO_SLOT;
        end else begin
          cmd_o.alloc    = 1'b1;
          cmd_o.quad_inc = 1'b1;
        end
      end
      ST_LOOKUP_CMP: begin
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          cmd_o.quad_inc = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid_o      = 1'b1;
        cmd_o.corner_inc = out_ready_i && !sts_i.rec_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/qbvs_datapath.sv
module qbvs_datapath import qbvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t out_data_o
);

  in_item_t         item_q;
  logic [31:0]      xr_q, yt_q;
  logic [QCW-1:0]   quad_count_q;
  logic [SCW-1:0]   slot_count_q;
  logic [SCW-1:0]   idx_q;
  logic [SCW-1:0]   slot_q;
  logic [1:0]       corner_q;
  kind_e            kind_q;
  logic [31:0]      rdata;
  logic [31:0]      ic_wide;
  logic [31:0]      sc_wide;
  logic [31:0]      sl_wide;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // Capture the item and its two corner sums; payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
      xr_q   <= sat_add(in_data_i.pos_x, in_data_i.size_x);
      yt_q   <= sat_add(in_data_i.pos_y, in_data_i.size_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_count_q <= '0;
      slot_count_q <= SCW'(1);
      idx_q        <= SCW'(1);
      slot_q       <= '0;
      corner_q     <= '0;
      kind_q       <= KIND_VERTEX;
    end else begin
      if (cmd_i.clear_scene) begin
        quad_count_q <= '0;
        slot_count_q <= SCW'(1);
      end
      if (cmd_i.capture) begin
        idx_q    <= SCW'(1);
        slot_q   <= '0;
        corner_q <= '0;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + SCW'(1);
      end
      if (cmd_i.take_hit) begin
        slot_q <= idx_q;
      end
      if (cmd_i.alloc) begin
        slot_q       <= slot_count_q;
        slot_count_q <= slot_count_q + SCW'(1);
      end
      if (cmd_i.quad_inc) begin
        quad_count_q <= quad_count_q + QCW'(1);
      end
      if (cmd_i.kind_ld) begin
        kind_q <= cmd_i.kind;
      end
      if (cmd_i.corner_inc) begin
        corner_q <= corner_q + 2'd1;
      end
    end
  end

  qbvs_ram #(
    .WIDTH(32),
    .DEPTH(TEXTURE_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.alloc),
    .waddr_i(slot_count_q[SLOT_AW-1:0]),
    .wdata_i(item_q.texture_id),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q[SLOT_AW-1:0]),
    .rdata_o(rdata)
  );

  assign sts_o.batch_full = (32'(quad_count_q) >= 32'(MAX_QUADS));
  assign sts_o.slots_full = (32'(slot_count_q) >= 32'(TEXTURE_SLOTS));
  assign sts_o.scan_done  = (idx_q >= slot_count_q);
  assign sts_o.hit        = (rdata == item_q.texture_id);
  assign sts_o.rec_last   = (kind_q != KIND_VERTEX) || (corner_q == 2'd3);

  assign ic_wide = 32'(quad_count_q) * 32'd6;
  assign sc_wide = 32'(slot_count_q);
  assign sl_wide = 32'(slot_q);

  always_comb begin
    out_data_o             = '0;
    out_data_o.record_kind = kind_q;
    out_data_o.is_last     = sts_o.rec_last;
    case (kind_q)
      KIND_VERTEX: begin
        out_data_o.tex_u      = corner_q[0] ^ corner_q[1];
        out_data_o.tex_v      = corner_q[1];
        out_data_o.vert_x     = (corner_q[0] ^ corner_q[1]) ? xr_q : item_q.pos_x;
        out_data_o.vert_y     = corner_q[1] ? yt_q : item_q.pos_y;
        out_data_o.vert_z     = item_q.pos_z;
        out_data_o.vert_color = item_q.color_rgba;
        out_data_o.slot_index = sl_wide[4:0];
      end
      KIND_SUMMARY: begin
        out_data_o.index_count  = ic_wide[15:0];
        out_data_o.slots_in_use = sc_wide[5:0];
      end
      default: out_data_o.is_last = 1'b1;
    endcase
  end

endmodule

FILE: rtl/quad_batch_vertex_setup.sv
// A flat quad's first vertex is offered in the cycle after acceptance; a textured quad
// first scans the slot table, a read and a compare per slot, until a hit or, on a miss,
// to the end, where it allocates a slot if one is free. Then come four output records;
// begin scene gives no record, end scene and drops give one; a new command waits for idle.
// Reset (rst_ni, asynchronous, active low): empty open scene, slot count 1, no quads;
// the slot handle RAM is not cleared, as only slots written this scene are read.
module quad_batch_vertex_setup import qbvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // Commands from the controller, status back from the datapath.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // The controller sequences one transaction at a time: accept, optional slot scan
  // (one RAM read and one compare per slot), then the records one per cycle while out_ready_i is high.
  qbvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .out_ready_i(out_ready_i),
    .sts_i      (dp_sts),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (dp_cmd)
  );

  // The datapath holds the captured item, saturated corner sums, the scene counters
  // and the slot handle RAM, and forms each record from the corner counter.
  qbvs_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .out_data_o(out_data_o)
  );

`ifndef NO_ASSERTIONS
  // Never offer a record while accepting a new transaction.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("record offered while input ready");

  // Anything but begin scene must leave idle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.cmd != CMD_BEGIN)) |=> !in_ready_o)
    else $error("still idle after accepting a non-begin transaction");

  // The last vertex of a quad is the (u0, v1) corner.
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.record_kind == KIND_VERTEX) && out_data_o.is_last)
      |-> (out_data_o.tex_v && !out_data_o.tex_u))
    else $error("last vertex is not the closing corner");

  // Never allocate a slot beyond the table.
  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.alloc |-> !dp_sts.slots_full)
    else $error("slot allocated with table full");
`endif

endmodule

FILE: test/qbvs_vertex_checker.sv
module qbvs_vertex_checker import qbvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        mismatches_o,
  output int        due_count_o,
  output int        vertices_o,
  output int        summaries_o,
  output int        drops_o
);

  // Batch state as the block should hold it.
  logic [31:0] slot_ids [TEXTURE_SLOTS];
  int          slots_used;
  int          quads;
  int          misses;
  int          n_vertex;
  int          n_summary;
  int          n_drop;
  out_item_t   due_records [$];

  function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return s[31:0];
  endfunction

  // Update the batch for one command and queue the records it must produce.
  function automatic void expand_command(input in_item_t c);
    out_item_t   r;
    int          slot;
    bit          hit;
    logic [31:0] x_far;
    logic [31:0] y_far;
    r    = '0;
    slot = 0;
    hit  = 1'b0;
    if (c.cmd == CMD_BEGIN) begin
      quads      = 0;
      slots_used = 1;
      return;
    end
    r.is_last = 1'b1;
    if (c.cmd == CMD_END) begin
      r.record_kind  = KIND_SUMMARY;
      r.index_count  = 16'(quads * 6);
      r.slots_in_use = 6'(slots_used);
      due_records.push_back(r);
      return;
    end
    // Batch full is tested ahead of any slot lookup.
    if (quads >= MAX_QUADS) begin
      r.record_kind = KIND_NO_ROOM;
      due_records.push_back(r);
      return;
    end
    if (c.cmd == CMD_TEX) begin
      for (int i = 1; i < slots_used && i < TEXTURE_SLOTS; i++) begin
        if (!hit && slot_ids[i] == c.texture_id) begin
          slot = i;
          hit  = 1'b1;
        end
      end
      if (!hit) begin
        if (slots_used >= TEXTURE_SLOTS) begin
          r.record_kind = KIND_NO_SLOT;
          due_records.push_back(r);
          return;
        end
        slot           = slots_used;
        slot_ids[slot] = c.texture_id;
        slots_used++;
      end
    end
    quads++;
    x_far = clamp_add(c.pos_x, c.size_x);
    y_far = clamp_add(c.pos_y, c.size_y);
    for (int k = 0; k < 4; k++) begin
      r             = '0;
      r.record_kind = KIND_VERTEX;
      r.tex_u       = (k == 1 || k == 2);
      r.tex_v       = (k >= 2);
      r.vert_x      = r.tex_u ? x_far : c.pos_x;
      r.vert_y      = r.tex_v ? y_far : c.pos_y;
      r.vert_z      = c.pos_z;
      r.vert_color  = c.color_rgba;
      r.slot_index  = 5'(slot);
      r.is_last     = (k == 3);
      due_records.push_back(r);
    end
  endfunction

  function automatic string field_diffs(input out_item_t e, input out_item_t a);
    string s;
    s = "";
    if (e.record_kind !== a.record_kind)
      s = {s, $sformatf(" kind exp %0d got %0d", e.record_kind, a.record_kind)};
    if (e.vert_x !== a.vert_x)
      s = {s, $sformatf(" x exp %h got %h", e.vert_x, a.vert_x)};
    if (e.vert_y !== a.vert_y)
      s = {s, $sformatf(" y exp %h got %h", e.vert_y, a.vert_y)};
    if (e.vert_z !== a.vert_z)
      s = {s, $sformatf(" z exp %h got %h", e.vert_z, a.vert_z)};
    if (e.tex_u !== a.tex_u)
      s = {s, $sformatf(" u exp %b got %b", e.tex_u, a.tex_u)};
    if (e.tex_v !== a.tex_v)
      s = {s, $sformatf(" v exp %b got %b", e.tex_v, a.tex_v)};
    if (e.vert_color !== a.vert_color)
      s = {s, $sformatf(" colour exp %h got %h", e.vert_color, a.vert_color)};
    if (e.slot_index !== a.slot_index)
      s = {s, $sformatf(" slot exp %0d got %0d", e.slot_index, a.slot_index)};
    if (e.is_last !== a.is_last)
      s = {s, $sformatf(" last exp %b got %b", e.is_last, a.is_last)};
    if (e.index_count !== a.index_count)
      s = {s, $sformatf(" indices exp %0d got %0d", e.index_count, a.index_count)};
    if (e.slots_in_use !== a.slots_in_use)
      s = {s, $sformatf(" slots exp %0d got %0d", e.slots_in_use, a.slots_in_use)};
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    string     diffs;
    if (!rst_ni) begin
      slots_used = 1;
      quads      = 0;
      misses     = 0;
      n_vertex   = 0;
      n_summary  = 0;
      n_drop     = 0;
      due_records.delete();
    end else begin
      // Check the result side first, then queue what the new command causes.
      if (out_valid_i && out_ready_i) begin
        if (due_records.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("unexpected record: kind %0d x %h y %h last %b",
                     out_data_i.record_kind, out_data_i.vert_x, out_data_i.vert_y,
                     out_data_i.is_last);
        end else begin
          want  = due_records.pop_front();
          diffs = field_diffs(want, out_data_i);
          case (kind_e'(want.record_kind))
            KIND_VERTEX:  n_vertex++;
            KIND_SUMMARY: n_summary++;
            default:      n_drop++;
          endcase
          if (diffs != "") begin
            misses++;
            if (misses <= 10) $display("record mismatch:%s", diffs);
          end
        end
      end
      if (in_valid_i && in_ready_i) expand_command(in_data_i);
    end
    mismatches_o <= misses;
    due_count_o  <= due_records.size();
    vertices_o   <= n_vertex;
    summaries_o  <= n_summary;
    drops_o      <= n_drop;
  end

endmodule

FILE: test/tb_quad_batch_vertex_setup.sv
module tb_quad_batch_vertex_setup;
  import qbvs_pkg::*;

  // Long receiver hold-off, watchdog limit and size of the random part.
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 180;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  int mismatches;
  int due_count;
  int n_vertex;
  int n_summary;
  int n_drop;
  int sent;
  int quiet_cycles;
  bit idle_on;        // random idling on both sides
  bit sink_hold_req;  // ask the receiver for one long hold-off

  quad_batch_vertex_setup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  qbvs_vertex_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatches),
    .due_count_o  (due_count),
    .vertices_o   (n_vertex),
    .summaries_o  (n_summary),
    .drops_o      (n_drop)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: alternate ready runs and stall bursts; take one long hold-off on request.
  initial begin : result_sink
    int left;
    bit hold_taken;
    left        = 0;
    hold_taken  = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (left > 0) begin
        left--;
      end else if (sink_hold_req && !hold_taken) begin
        hold_taken   = 1'b1;
        left         = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        left         = $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        left         = idle_on ? $urandom_range(0, 59) : 0;
        out_ready_i <= 1'b1;
      end
    end
  end

  // Coordinates: mostly small signed values, some extremes, some anything at all.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic in_item_t fixed_item(input cmd_e c, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z,
                                          input logic [31:0] w, input logic [31:0] h,
                                          input logic [31:0] col, input logic [31:0] tid);
    in_item_t it;
    it.cmd        = c;
    it.pos_x      = x;
    it.pos_y      = y;
    it.pos_z      = z;
    it.size_x     = w;
    it.size_y     = h;
    it.color_rgba = col;
    it.texture_id = tid;
    return it;
  endfunction

  function automatic in_item_t random_item(input cmd_e c, input logic [31:0] tid);
    return fixed_item(c, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), $urandom(), tid);
  endfunction

  // Offer one command, after an optional idle burst, and hold it until accepted.
  task automatic offer(input in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Drop valid and wait until every queued record has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
  endtask

  initial begin : stimulus
    int          directed_sent;
    int          scene;
    int          n_quads;
    int          pool_n;
    logic [31:0] pool_base;
    logic [31:0] tid;
    rst_ni        = 1'b0;
    idle_on       = 1'b1;
    sink_hold_req = 1'b0;
    sent          = 0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: draw before any begin scene, saturation both ways, slot hit and miss,
    // repeated begin and end, and all-zero and all-ones fields.
    offer(fixed_item(CMD_TEX, '0, '0, '0, '0, '0, '0, 32'h0000_0000));
    offer(fixed_item(CMD_FLAT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff));
    offer(fixed_item(CMD_END, '0, '0, '0, '0, '0, '0, '0));
    offer(fixed_item(CMD_BEGIN, '1, '1, '1, '1, '1, '1, '1));
    offer(fixed_item(CMD_BEGIN, '0, '0, '0, '0, '0, '0, '0));
    offer(fixed_item(CMD_END, '1, '1, '1, '1, '1, '1, '1));
    offer(fixed_item(CMD_TEX, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h0000_0000, 32'hffff_ffff));
    offer(fixed_item(CMD_TEX, '1, '1, '1, '1, '1, '1, 32'h0000_0000));
    offer(fixed_item(CMD_TEX, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0010_0000,
                     32'h0020_0000, 32'h11223344, 32'hffff_ffff));
    offer(fixed_item(CMD_FLAT, '0, '0, '0, '0, '0, '0, '0));
    offer(fixed_item(CMD_FLAT, 32'h7fff_0000, 32'h8000_0000, 32'hffff_0000, 32'h0001_0000,
                     32'hffff_ffff, 32'h8040_20ff, 32'h5555_aaaa));
    offer(random_item(CMD_TEX, $urandom()));
    offer(fixed_item(CMD_END, '0, '0, '0, '0, '0, '0, '0));
    offer(fixed_item(CMD_END, '0, '0, '0, '0, '0, '0, '0));
    offer(random_item(CMD_FLAT, $urandom()));
    offer(fixed_item(CMD_BEGIN, '0, '0, '0, '0, '0, '0, '0));
    offer(fixed_item(CMD_END, '0, '0, '0, '0, '0, '0, '0));
    directed_sent = sent;

    // Random scenes: mostly begin, a run of quads drawing on a small texture pool, end.
    // Now and then a scene of noise, a missing begin or an extra end mid-scene.
    scene = 0;
    while (sent - directed_sent < RANDOM_ITEMS) begin
      scene++;
      pool_base = $urandom();
      pool_n    = $urandom_range(1, 40);
      if (scene == 3) sink_hold_req = 1'b1;
      if (scene == 6) begin
        // Fill every slot with fresh ids, overflow twice, then hit an early slot.
        offer(random_item(CMD_BEGIN, $urandom()));
        for (int i = 0; i < TEXTURE_SLOTS + 1; i++)
          offer(random_item(CMD_TEX, pool_base + i));
        offer(random_item(CMD_TEX, pool_base + 7));
        offer(random_item(CMD_FLAT, $urandom()));
        offer(random_item(CMD_END, $urandom()));
        settle();
      end else if (scene % 7 == 0) begin
        repeat ($urandom_range(1, 6))
          offer(random_item(cmd_e'($urandom_range(0, 3)), $urandom()));
      end else begin
        n_quads = (scene == 3) ? 10 : $urandom_range(1, 14);
        if ($urandom_range(0, 9) != 0) offer(random_item(CMD_BEGIN, $urandom()));
        repeat (n_quads) begin
          tid = ($urandom_range(0, 7) == 0) ? $urandom()
                                            : pool_base + $urandom_range(0, pool_n - 1);
          offer(random_item($urandom_range(0, 1) ? CMD_TEX : CMD_FLAT, tid));
          if ($urandom_range(0, 11) == 0) offer(random_item(CMD_END, $urandom()));
        end
        offer(random_item(CMD_END, $urandom()));
      end
    end
    settle();

    // Last part, no idling: a short run of quads back to back, a summary, and a
    // fresh scene after it.
    idle_on = 1'b0;
    offer(random_item(CMD_BEGIN, $urandom()));
    repeat (6) offer(random_item(CMD_FLAT, $urandom()));
    offer(random_item(CMD_TEX, $urandom()));
    offer(random_item(CMD_END, $urandom()));
    offer(random_item(CMD_BEGIN, $urandom()));
    offer(random_item(CMD_TEX, $urandom()));
    offer(random_item(CMD_END, $urandom()));
    settle();
    // Let any late stray record show itself before the verdict.
    repeat (40) @(posedge clk_i);

    $display("Sent %0d commands: %0d directed, random scenes, a slot table overflow",
             sent, directed_sent);
    $display("Checked %0d vertices, %0d summaries, %0d dropped quads; one %0d-cycle hold-off",
             n_vertex, n_summary, n_drop, HOLD_CYCLES);
    if (mismatches == 0 && due_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
